[design/skt_pkg.sv]
// Shared types and constants for the sorted key table.
`default_nettype none

package skt_pkg;

  localparam int KEY_W = 17;
  localparam int REF_W = 16;
  localparam logic [KEY_W-1:0] KEY_MAX_VALID = 17'd99999;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_KEY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECIDE = 3'd1,
    S_READ   = 3'd2,
    S_STEP   = 3'd3,
    S_PLACE  = 3'd4,
    S_PUT    = 3'd5,
    S_FINAL  = 3'd6
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    clr_count;
    logic    inc_count;
    logic    dec_count;
    logic    idx_to_top;
    logic    idx_to_zero;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    logic    wr_up;
    logic    wr_new_next;
    logic    wr_new_idx;
    logic    wr_down;
    logic    clr_found;
    logic    set_found;
    logic    set_status;
    status_t status;
    logic    load_entry;
    logic    load_final;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic key_ok;
    logic full;
    logic empty;
    logic at_top;
    logic at_zero;
    logic rd_ge;
    logic rd_eq;
    logic found;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[design/skt_ctrl.sv]
// Command sequencer for the sorted key table.
`default_nettype none

module skt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire skt_pkg::stat_t stat,
  output skt_pkg::ctrl_t      ctrl
);

  skt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = skt_pkg::S_DECIDE;
      end
      skt_pkg::S_DECIDE: begin
        case (stat.cmd)
          skt_pkg::CMD_INSERT: begin
            if (stat.full || !stat.key_ok) state_nxt = skt_pkg::S_FINAL;
            else if (stat.empty)           state_nxt = skt_pkg::S_PLACE;
            else                           state_nxt = skt_pkg::S_READ;
          end
          skt_pkg::CMD_DELETE: begin
            if (!stat.key_ok || stat.empty) state_nxt = skt_pkg::S_FINAL;
            else                            state_nxt = skt_pkg::S_READ;
          end
          skt_pkg::CMD_LIST: begin
            if (stat.empty) state_nxt = skt_pkg::S_FINAL;
            else            state_nxt = skt_pkg::S_READ;
          end
          default: state_nxt = skt_pkg::S_FINAL;
        endcase
      end
      skt_pkg::S_READ: state_nxt = skt_pkg::S_STEP;
      skt_pkg::S_STEP: begin
        case (stat.cmd)
          skt_pkg::CMD_INSERT: begin
            if (!stat.rd_ge)      state_nxt = skt_pkg::S_FINAL;
            else if (stat.at_zero) state_nxt = skt_pkg::S_PLACE;
            else                   state_nxt = skt_pkg::S_READ;
          end
          skt_pkg::CMD_DELETE: begin
            state_nxt = stat.at_top ? skt_pkg::S_FINAL : skt_pkg::S_READ;
          end
          skt_pkg::CMD_LIST: state_nxt = skt_pkg::S_PUT;
          default:           state_nxt = skt_pkg::S_IDLE;
        endcase
      end
      skt_pkg::S_PLACE: state_nxt = skt_pkg::S_FINAL;
      skt_pkg::S_PUT: begin
        if (stat.out_free) state_nxt = stat.at_top ? skt_pkg::S_IDLE : skt_pkg::S_READ;
      end
      skt_pkg::S_FINAL: begin
        if (stat.out_free) state_nxt = skt_pkg::S_IDLE;
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state_r)
      skt_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_in = in_valid;
      end
      skt_pkg::S_DECIDE: begin
        ctrl.set_status = 1'b1;
        ctrl.status     = skt_pkg::ST_OK;
        case (stat.cmd)
          skt_pkg::CMD_INSERT: begin
            if (stat.full) begin
              ctrl.status = skt_pkg::ST_FULL;
            end else if (!stat.key_ok) begin
              ctrl.status = skt_pkg::ST_BAD_KEY;
            end else if (stat.empty) begin
              ctrl.idx_to_zero = 1'b1;
            end else begin
              ctrl.idx_to_top = 1'b1;
            end
          end
          skt_pkg::CMD_DELETE: begin
            if (!stat.key_ok) begin
              ctrl.status = skt_pkg::ST_BAD_KEY;
            end else if (stat.empty) begin
              ctrl.status = skt_pkg::ST_NOT_FOUND;
            end else begin
              ctrl.idx_to_zero = 1'b1;
              ctrl.clr_found   = 1'b1;
            end
          end
          skt_pkg::CMD_LIST: begin
            if (stat.empty) ctrl.status = skt_pkg::ST_EMPTY;
            else            ctrl.idx_to_zero = 1'b1;
          end
          default: ctrl.clr_count = 1'b1;
        endcase
      end
      skt_pkg::S_READ: ctrl.rd_en = 1'b1;
      skt_pkg::S_STEP: begin
        case (stat.cmd)
          skt_pkg::CMD_INSERT: begin
            if (stat.rd_ge) begin
              ctrl.wr_up   = 1'b1;
              ctrl.idx_dec = !stat.at_zero;
            end else begin
              ctrl.wr_new_next = 1'b1;
              ctrl.inc_count   = 1'b1;
            end
          end
          skt_pkg::CMD_DELETE: begin
            if (stat.found)      ctrl.wr_down   = 1'b1;
            else if (stat.rd_eq) ctrl.set_found = 1'b1;
            if (stat.at_top) begin
              ctrl.set_status = 1'b1;
              if (stat.found || stat.rd_eq) begin
                ctrl.dec_count = 1'b1;
                ctrl.status    = skt_pkg::ST_OK;
              end else begin
                ctrl.status = skt_pkg::ST_NOT_FOUND;
              end
            end else begin
              ctrl.idx_inc = 1'b1;
            end
          end
          default: ;
        endcase
      end
      skt_pkg::S_PLACE: begin
        ctrl.wr_new_idx = 1'b1;
        ctrl.inc_count  = 1'b1;
      end
      skt_pkg::S_PUT: begin
        if (stat.out_free) begin
          ctrl.load_entry = 1'b1;
          ctrl.idx_inc    = !stat.at_top;
        end
      end
      skt_pkg::S_FINAL: ctrl.load_final = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/skt_datapath.sv]
// Entry memory, walk index, entry count and result register of the sorted key table.
`default_nettype none

module skt_datapath #(
  parameter int CAPACITY = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire skt_pkg::ctrl_t             ctrl,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [skt_pkg::KEY_W-1:0]  in_key,
  input  wire logic [skt_pkg::REF_W-1:0]  in_ref,
  output skt_pkg::stat_t                  stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic [skt_pkg::KEY_W-1:0]       out_key,
  output logic [skt_pkg::REF_W-1:0]       out_ref,
  output logic                            out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [skt_pkg::KEY_W-1:0] mem_key [CAPACITY];
  logic [skt_pkg::REF_W-1:0] mem_ref [CAPACITY];

  skt_pkg::cmd_t             cmd_r;
  skt_pkg::status_t          res_st_r;
  logic [skt_pkg::KEY_W-1:0] key_r, rd_key_r;
  logic [skt_pkg::REF_W-1:0] ref_r, rd_ref_r;
  logic [CNT_W-1:0]          count_r, idx_r;
  logic                      found_r;
  logic                      out_valid_r;

  logic [CNT_W-1:0]          count_m1, wr_addr;
  logic                      wr_en, out_free;
  logic [skt_pkg::KEY_W-1:0] wr_key;
  logic [skt_pkg::REF_W-1:0] wr_ref;

  assign count_m1 = count_r - CNT_W'(1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.cmd      = cmd_r;
    stat.key_ok   = (key_r != '0) && (key_r <= skt_pkg::KEY_MAX_VALID);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.empty    = (count_r == '0);
    stat.at_top   = (idx_r == count_m1);
    stat.at_zero  = (idx_r == '0);
    stat.rd_ge    = (rd_key_r >= key_r);
    stat.rd_eq    = (rd_key_r == key_r);
    stat.found    = found_r;
    stat.out_free = out_free;
  end

  // Shifts move the entry just read; new entries take the latched request.
  always_comb begin
    wr_en   = ctrl.wr_up || ctrl.wr_new_next || ctrl.wr_new_idx || ctrl.wr_down;
    wr_addr = idx_r;
    if (ctrl.wr_up || ctrl.wr_new_next) wr_addr = idx_r + CNT_W'(1);
    else if (ctrl.wr_down)              wr_addr = idx_r - CNT_W'(1);
    if (ctrl.wr_up || ctrl.wr_down) begin
      wr_key = rd_key_r;
      wr_ref = rd_ref_r;
    end else begin
      wr_key = key_r;
      wr_ref = ref_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr[AW-1:0]] <= wr_key;
      mem_ref[wr_addr[AW-1:0]] <= wr_ref;
    end
    if (ctrl.rd_en) begin
      rd_key_r <= mem_key[idx_r[AW-1:0]];
      rd_ref_r <= mem_ref[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= skt_pkg::cmd_t'(in_cmd);
      key_r <= in_key;
      ref_r <= in_ref;
    end
    if (ctrl.set_status) res_st_r <= ctrl.status;
    if (ctrl.load_entry) begin
      out_status <= skt_pkg::ST_OK;
      out_key    <= rd_key_r;
      out_ref    <= rd_ref_r;
      out_last   <= stat.at_top;
    end else if (ctrl.load_final) begin
      out_status <= res_st_r;
      out_key    <= key_r;
      out_ref    <= '0;
      out_last   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.clr_count)      count_r <= '0;
      else if (ctrl.inc_count) count_r <= count_r + CNT_W'(1);
      else if (ctrl.dec_count) count_r <= count_m1;

      if (ctrl.idx_to_top)       idx_r <= count_m1;
      else if (ctrl.idx_to_zero) idx_r <= '0;
      else if (ctrl.idx_inc)     idx_r <= idx_r + CNT_W'(1);
      else if (ctrl.idx_dec)     idx_r <= idx_r - CNT_W'(1);

      if (ctrl.clr_found)      found_r <= 1'b0;
      else if (ctrl.set_found) found_r <= 1'b1;

      if (ctrl.load_entry || ctrl.load_final) out_valid_r <= 1'b1;
      else if (out_ready)                     out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.inc_count |-> !stat.full)
    else $error("insert into a full table");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr < CNT_W'(CAPACITY)))
    else $error("write beyond table");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.load_entry || ctrl.load_final) |-> out_free)
    else $error("result loaded over a pending one");

endmodule

`default_nettype wire

[design/sorted_key_table.sv]
// Top level of the sorted key table: stream ports, controller and datapath.
// Clear and rejected requests go straight to their result; insert walks down from the top,
//   shifting each larger entry up, and delete walks every stored entry.
// List: one result per stored entry, each read from the table in turn.
// Requests are taken one at a time; output stalls hold back the list and final results.
// Reset (rst_n low, synchronous): table empty, no result pending, controller idle.
`default_nettype none

module sorted_key_table #(
  parameter int CAPACITY = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [16:0] key, [32:17] record_ref, [39:33] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [16:0] out_key, [32:17] out_ref, [39:33] zero
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast   // final result of the request
);

  skt_pkg::ctrl_t ctrl;
  skt_pkg::stat_t stat;

  logic [skt_pkg::KEY_W-1:0] res_key;
  logic [skt_pkg::REF_W-1:0] res_ref;

  // Sequence each request: decide, walk the table, then hand the result over.
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Hold the entries, walk index and count; the output register parts the two sides,
  // so a new request is taken while a finished result still waits.
  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_cmd     (in_tuser),
    .in_key     (in_tdata[16:0]),
    .in_ref     (in_tdata[32:17]),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_key    (res_key),
    .out_ref    (res_ref),
    .out_last   (out_tlast)
  );

  // Pack the result fields, low field first, zero fill to whole bytes.
  assign out_tdata = {7'd0, res_ref, res_key};

endmodule

`default_nettype wire
